// ===== hdl/dsmc_pkg.sv =====
// shared types, constants and tables of the dual servo motion controller
`timescale 1ns / 1ps
package dsmc_pkg;

    localparam int QUEUE_DEPTH = 128;
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int DUTY_BITS = 14;

    localparam int PULSE_MIN_US = 500;
    localparam int PULSE_MID_US = 1500;
    localparam int PULSE_MAX_US = 2500;
    localparam int PERIOD_US = 20000;
    localparam int ANGLE_MID = 90;
    localparam int ANGLE_MAX = 180;
    localparam logic [7:0] ANGLE_MAX_8 = 8'd180;
    localparam logic [7:0] X_RESET_DEG = 8'd90;
    localparam logic [7:0] Y_RESET_DEG = 8'd120;
    localparam logic [9:0] STEP_MS_RESET = 10'd20;

    localparam int DIV_W = 24;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam logic [2:0] CMD_SET = 3'd0;
    localparam logic [2:0] CMD_MOVE = 3'd1;
    localparam logic [2:0] CMD_SYNC = 3'd2;
    localparam logic [2:0] CMD_CANCEL = 3'd3;
    localparam logic [2:0] CMD_TICK = 3'd4;

    localparam logic [1:0] KIND_X = 2'd0;
    localparam logic [1:0] KIND_Y = 2'd1;
    localparam logic [1:0] KIND_SYNC = 2'd2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_DROPPED = 2'd2;

    localparam logic [1:0] REG_Y_MIN = 2'd0;
    localparam logic [1:0] REG_Y_MAX = 2'd1;
    localparam logic [1:0] REG_STEP_MS = 2'd2;

    typedef enum logic [2:0] {
        OP_SET,
        OP_SET_BOTH,
        OP_ENQ,
        OP_CANCEL,
        OP_TICK,
        OP_BAD
    } op_code_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_RD,
        S_POP,
        S_NWAIT,
        S_ADV,
        S_MUL,
        S_DSTART,
        S_DWAIT,
        S_FIN
    } back_state_t;

    typedef struct packed {
        op_code_t    op;
        logic        axis;
        logic [1:0]  kind;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [15:0] ms;
    } op_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [15:0] ms;
    } entry_t;

    typedef struct packed {
        logic [7:0] y_min;
        logic [7:0] y_max;
        logic [9:0] step_ms;
    } cfg_t;

    typedef logic [DUTY_BITS-1:0] duty_table_t [0:ANGLE_MAX];

    function automatic duty_table_t build_duty();
        duty_table_t t;
        int pulse;
        int q;
        for (int ang = 0; ang <= ANGLE_MAX; ang++)
        begin
            if (ang >= ANGLE_MID)
            begin
                q = ((ang - ANGLE_MID) * (PULSE_MAX_US - PULSE_MID_US) + ANGLE_MID / 2)
                    / ANGLE_MID;
                pulse = PULSE_MID_US + q;
            end
            else
            begin
                q = ((ANGLE_MID - ang) * (PULSE_MAX_US - PULSE_MID_US) + ANGLE_MID / 2)
                    / ANGLE_MID;
                pulse = PULSE_MID_US - q;
            end
            if (pulse < PULSE_MIN_US)
                pulse = PULSE_MIN_US;
            if (pulse > PULSE_MAX_US)
                pulse = PULSE_MAX_US;
            t[ang] = DUTY_BITS'((pulse * (1 << DUTY_BITS) + PERIOD_US / 2) / PERIOD_US);
        end
        return t;
    endfunction

    localparam duty_table_t DUTY_LUT = build_duty();

endpackage

// ===== hdl/dual_servo_motion_controller.sv =====
// top level: config registers, command front end, queue and motion back end
// set, cancel, queue and idle-tick commands run through the exec and finish states to the result
// register; a tick that starts a move first divides its duration by the step period, and each
// step but the last then runs a 24-bit divide per interpolated axis (sync moves do two in turn)
// throughput: one command at a time in the back end; two more wait in the queue
// reset: asynchronous; X at 90 and Y at 120 degrees, queue empty, no move
`timescale 1ns / 1ps
module dual_servo_motion_controller
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [3:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [2:0]                     cmd,
    input  logic                           axis_sel,
    input  logic [7:0]                     angle_a,
    input  logic [7:0]                     angle_b,
    input  logic [15:0]                    move_ms,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     status,
    output logic [dsmc_pkg::DUTY_BITS-1:0] duty_x,
    output logic [dsmc_pkg::DUTY_BITS-1:0] duty_y,
    output logic [7:0]                     pos_x,
    output logic [7:0]                     pos_y,
    output logic [7:0]                     queued,
    output logic                           moving
);

    dsmc_pkg::cfg_t cfg_reg;
    dsmc_pkg::cfg_t cfg_next;
    logic           wr_en;
    logic [1:0]     reg_idx;
    logic           q_push;
    logic           q_pop;
    logic           q_full;
    logic           q_empty;
    dsmc_pkg::op_t  push_op;
    dsmc_pkg::op_t  head_op;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                dsmc_pkg::REG_Y_MIN:
                    cfg_next.y_min = pwdata[7:0];
                dsmc_pkg::REG_Y_MAX:
                    cfg_next.y_max = pwdata[7:0];
                dsmc_pkg::REG_STEP_MS:
                    cfg_next.step_ms = pwdata[9:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            dsmc_pkg::REG_Y_MIN:
                prdata = {24'd0, cfg_reg.y_min};
            dsmc_pkg::REG_Y_MAX:
                prdata = {24'd0, cfg_reg.y_max};
            dsmc_pkg::REG_STEP_MS:
                prdata = {22'd0, cfg_reg.step_ms};
            default:
                prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.y_min <= 8'd0;
            cfg_reg.y_max <= dsmc_pkg::ANGLE_MAX_8;
            cfg_reg.step_ms <= dsmc_pkg::STEP_MS_RESET;
        end
        else
            cfg_reg <= cfg_next;
    end

    dsmc_front u_front
    (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .axis_sel (axis_sel),
        .angle_a  (angle_a),
        .angle_b  (angle_b),
        .move_ms  (move_ms),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_op     (push_op)
    );

    dsmc_opq u_opq
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (push_op),
        .pop     (q_pop),
        .head_op (head_op),
        .full    (q_full),
        .empty   (q_empty)
    );

    dsmc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_op      (head_op),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .duty_x    (duty_x),
        .duty_y    (duty_y),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .queued    (queued),
        .moving    (moving)
    );

endmodule

// ===== hdl/dsmc_front.sv =====
// front end: beat acceptance and command classification
`timescale 1ns / 1ps
module dsmc_front
(
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         cmd,
    input  logic               axis_sel,
    input  logic [7:0]         angle_a,
    input  logic [7:0]         angle_b,
    input  logic [15:0]        move_ms,
    input  logic               q_full,
    output logic               q_push,
    output dsmc_pkg::op_t      q_op
);

    logic a_bad;
    logic b_bad;

    assign a_bad = angle_a > dsmc_pkg::ANGLE_MAX_8;
    assign b_bad = angle_b > dsmc_pkg::ANGLE_MAX_8;
    assign in_stall = q_full;
    assign q_push = in_valid && !q_full;

    always_comb
    begin
        q_op.axis = axis_sel;
        q_op.kind = {1'b0, axis_sel};
        q_op.a = angle_a;
        q_op.b = angle_b;
        q_op.ms = move_ms;
        case (cmd)
            dsmc_pkg::CMD_SET:
                q_op.op = a_bad ? dsmc_pkg::OP_BAD : dsmc_pkg::OP_SET;
            dsmc_pkg::CMD_MOVE:
            begin
                if (a_bad)
                    q_op.op = dsmc_pkg::OP_BAD;
                else if (move_ms == 16'd0)
                    q_op.op = dsmc_pkg::OP_SET;
                else
                    q_op.op = dsmc_pkg::OP_ENQ;
            end
            dsmc_pkg::CMD_SYNC:
            begin
                q_op.kind = dsmc_pkg::KIND_SYNC;
                if (a_bad || b_bad)
                    q_op.op = dsmc_pkg::OP_BAD;
                else if (move_ms == 16'd0)
                    q_op.op = dsmc_pkg::OP_SET_BOTH;
                else
                    q_op.op = dsmc_pkg::OP_ENQ;
            end
            dsmc_pkg::CMD_CANCEL:
                q_op.op = dsmc_pkg::OP_CANCEL;
            dsmc_pkg::CMD_TICK:
                q_op.op = dsmc_pkg::OP_TICK;
            default:
                q_op.op = dsmc_pkg::OP_BAD;
        endcase
    end

endmodule

// ===== hdl/dsmc_opq.sv =====
// two-entry queue of classified commands between front and back
`timescale 1ns / 1ps
module dsmc_opq
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dsmc_pkg::op_t push_op,
    input  logic          pop,
    output dsmc_pkg::op_t head_op,
    output logic          full,
    output logic          empty
);

    dsmc_pkg::op_t slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    assign full = cnt_reg == 2'd2;
    assign empty = cnt_reg == 2'd0;
    assign head_op = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_op;
    end

endmodule

// ===== hdl/dsmc_div.sv =====
// radix-2 restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module dsmc_div
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [dsmc_pkg::DIV_W-1:0] dividend,
    input  logic [15:0]                divisor,
    output logic                       done,
    output logic [dsmc_pkg::DIV_W-1:0] quotient
);

    logic [15:0]                    rem_reg;
    logic [15:0]                    rem_next;
    logic [dsmc_pkg::DIV_W-1:0]     quo_reg;
    logic [dsmc_pkg::DIV_W-1:0]     quo_next;
    logic [15:0]                    dsr_reg;
    logic [15:0]                    dsr_next;
    logic [dsmc_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [dsmc_pkg::DIV_CNT_W-1:0] cnt_next;
    logic                           busy_reg;
    logic                           busy_next;
    logic                           done_reg;
    logic                           done_next;
    logic [16:0]                    shifted;
    logic                           fits;

    assign done = done_reg;
    assign quotient = quo_reg;
    assign shifted = {rem_reg, quo_reg[dsmc_pkg::DIV_W-1]};
    assign fits = shifted >= {1'b0, dsr_reg};

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        dsr_next = dsr_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = 16'd0;
            quo_next = dividend;
            dsr_next = divisor;
            cnt_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? 16'(shifted - {1'b0, dsr_reg}) : shifted[15:0];
            quo_next = {quo_reg[dsmc_pkg::DIV_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == dsmc_pkg::DIV_CNT_W'(dsmc_pkg::DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

endmodule

// ===== hdl/dsmc_back.sv =====
// back end: move queue, interpolation sequencer and result register
`timescale 1ns / 1ps
module dsmc_back
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  dsmc_pkg::cfg_t                 cfg,
    input  logic                           q_empty,
    input  dsmc_pkg::op_t                  q_op,
    output logic                           q_pop,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     status,
    output logic [dsmc_pkg::DUTY_BITS-1:0] duty_x,
    output logic [dsmc_pkg::DUTY_BITS-1:0] duty_y,
    output logic [7:0]                     pos_x,
    output logic [7:0]                     pos_y,
    output logic [7:0]                     queued,
    output logic                           moving
);

    localparam int QW = dsmc_pkg::QW;
    localparam int CW = dsmc_pkg::CW;
    localparam int DEPTH = dsmc_pkg::QUEUE_DEPTH;

    dsmc_pkg::back_state_t state_reg;
    dsmc_pkg::back_state_t state_next;

    dsmc_pkg::entry_t mem [DEPTH];
    dsmc_pkg::entry_t rd_reg;
    logic             mem_we;
    logic [QW-1:0]    mem_wa;
    dsmc_pkg::entry_t mem_wd;

    dsmc_pkg::op_t op_reg;
    dsmc_pkg::op_t op_next;
    logic [1:0]    status_reg;
    logic [1:0]    status_next;
    logic [7:0]    ang_x_reg;
    logic [7:0]    ang_x_next;
    logic [7:0]    ang_y_reg;
    logic [7:0]    ang_y_next;
    logic [QW-1:0] head_reg;
    logic [QW-1:0] head_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          active_reg;
    logic          active_next;
    logic [1:0]    kind_reg;
    logic [1:0]    kind_next;
    logic [7:0]    start_x_reg;
    logic [7:0]    start_x_next;
    logic [7:0]    start_y_reg;
    logic [7:0]    start_y_next;
    logic [7:0]    tgt_x_reg;
    logic [7:0]    tgt_x_next;
    logic [7:0]    tgt_y_reg;
    logic [7:0]    tgt_y_next;
    logic [15:0]   total_reg;
    logic [15:0]   total_next;
    logic [15:0]   idx_reg;
    logic [15:0]   idx_next;
    logic          cur_ax_reg;
    logic          cur_ax_next;
    logic          neg_reg;
    logic          neg_next;
    logic [23:0]   prod_reg;
    logic [23:0]   prod_next;

    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [1:0]                     out_status_reg;
    logic [dsmc_pkg::DUTY_BITS-1:0] out_duty_x_reg;
    logic [dsmc_pkg::DUTY_BITS-1:0] out_duty_y_reg;
    logic [7:0]                     out_pos_x_reg;
    logic [7:0]                     out_pos_y_reg;
    logic [7:0]                     out_queued_reg;
    logic                           out_moving_reg;
    logic                           out_load;

    logic                           div_start;
    logic [dsmc_pkg::DIV_W-1:0]     div_dividend;
    logic [15:0]                    div_divisor;
    logic                           div_done;
    logic [dsmc_pkg::DIV_W-1:0]     div_quo;

    logic [7:0]    y_lo;
    logic [7:0]    y_hi;
    logic [7:0]    clamp_a;
    logic [7:0]    clamp_b;
    logic [7:0]    clamp_e_a;
    logic [7:0]    clamp_e_b;
    logic          q_is_full;
    logic [QW-1:0] head_inc;
    logic [QW:0]   tail_sum;
    logic [QW-1:0] tail_addr;
    logic [9:0]    per;
    logic          pop_single_y;
    logic [7:0]    pop_target;
    logic          pop_go;
    logic [15:0]   step_i;
    logic          step_last;
    logic [7:0]    cur_s;
    logic [7:0]    cur_t;
    logic [7:0]    cur_mag;
    logic [7:0]    div_q8;
    logic [7:0]    interp_v;
    logic [31:0]   count_wide;

    function automatic logic [7:0] clamp_y(input logic [7:0] v, input logic [7:0] lo,
                                           input logic [7:0] hi);
        logic [7:0] r;
        r = v;
        if (r < lo)
            r = lo;
        if (r > hi)
            r = hi;
        return r;
    endfunction

    dsmc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // shared helpers
    always_comb
    begin
        y_lo = (cfg.y_min > dsmc_pkg::ANGLE_MAX_8) ? dsmc_pkg::ANGLE_MAX_8 : cfg.y_min;
        y_hi = (cfg.y_max > dsmc_pkg::ANGLE_MAX_8) ? dsmc_pkg::ANGLE_MAX_8 : cfg.y_max;
        clamp_a = clamp_y(op_reg.a, y_lo, y_hi);
        clamp_b = clamp_y(op_reg.b, y_lo, y_hi);
        clamp_e_a = clamp_y(rd_reg.a, y_lo, y_hi);
        clamp_e_b = clamp_y(rd_reg.b, y_lo, y_hi);
        q_is_full = count_reg == CW'(DEPTH);
        head_inc = (head_reg == QW'(DEPTH - 1)) ? '0 : QW'(head_reg + 1'b1);
        tail_sum = (QW + 1)'(head_reg) + (QW + 1)'(count_reg);
        tail_addr = (tail_sum >= (QW + 1)'(DEPTH)) ? QW'(tail_sum - (QW + 1)'(DEPTH))
                                                   : tail_sum[QW-1:0];
        per = (cfg.step_ms == 10'd0) ? 10'd1 : cfg.step_ms;
        pop_single_y = rd_reg.kind[0];
        pop_target = pop_single_y ? clamp_e_a : rd_reg.a;
        pop_go = (rd_reg.kind == dsmc_pkg::KIND_SYNC)
              || (pop_target != (pop_single_y ? ang_y_reg : ang_x_reg));
        step_i = idx_reg + 1'b1;
        step_last = step_i >= total_reg;
        cur_s = cur_ax_reg ? start_y_reg : start_x_reg;
        cur_t = cur_ax_reg ? tgt_y_reg : tgt_x_reg;
        cur_mag = (cur_t < cur_s) ? 8'(cur_s - cur_t) : 8'(cur_t - cur_s);
        div_q8 = div_quo[7:0];
        interp_v = neg_reg ? 8'(cur_s - div_q8) : 8'(cur_s + div_q8);
        count_wide = 32'(count_reg);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dsmc_pkg::S_IDLE:
                if (!q_empty)
                    state_next = dsmc_pkg::S_EXEC;
            dsmc_pkg::S_EXEC:
            begin
                state_next = dsmc_pkg::S_FIN;
                if (op_reg.op == dsmc_pkg::OP_TICK)
                begin
                    if (active_reg)
                        state_next = dsmc_pkg::S_ADV;
                    else if (count_reg != '0)
                        state_next = dsmc_pkg::S_RD;
                end
            end
            dsmc_pkg::S_RD:
                state_next = dsmc_pkg::S_POP;
            dsmc_pkg::S_POP:
                state_next = pop_go ? dsmc_pkg::S_NWAIT : dsmc_pkg::S_FIN;
            dsmc_pkg::S_NWAIT:
                if (div_done)
                    state_next = dsmc_pkg::S_ADV;
            dsmc_pkg::S_ADV:
                state_next = step_last ? dsmc_pkg::S_FIN : dsmc_pkg::S_MUL;
            dsmc_pkg::S_MUL:
                state_next = dsmc_pkg::S_DSTART;
            dsmc_pkg::S_DSTART:
                state_next = dsmc_pkg::S_DWAIT;
            dsmc_pkg::S_DWAIT:
                if (div_done)
                    state_next = (kind_reg == dsmc_pkg::KIND_SYNC && !cur_ax_reg)
                               ? dsmc_pkg::S_MUL : dsmc_pkg::S_FIN;
            dsmc_pkg::S_FIN:
                if (out_load)
                    state_next = dsmc_pkg::S_IDLE;
            default:
                state_next = dsmc_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        op_next = op_reg;
        status_next = status_reg;
        ang_x_next = ang_x_reg;
        ang_y_next = ang_y_reg;
        head_next = head_reg;
        count_next = count_reg;
        active_next = active_reg;
        kind_next = kind_reg;
        start_x_next = start_x_reg;
        start_y_next = start_y_reg;
        tgt_x_next = tgt_x_reg;
        tgt_y_next = tgt_y_reg;
        total_next = total_reg;
        idx_next = idx_reg;
        cur_ax_next = cur_ax_reg;
        neg_next = neg_reg;
        prod_next = prod_reg;
        q_pop = 1'b0;
        mem_we = 1'b0;
        mem_wa = tail_addr;
        mem_wd = '{kind: op_reg.kind, a: op_reg.a, b: op_reg.b, ms: op_reg.ms};
        div_start = 1'b0;
        div_dividend = dsmc_pkg::DIV_W'(rd_reg.ms);
        div_divisor = 16'(per);
        out_load = 1'b0;
        case (state_reg)
            dsmc_pkg::S_IDLE:
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    op_next = q_op;
                    status_next = dsmc_pkg::ST_OK;
                end
            dsmc_pkg::S_EXEC:
                case (op_reg.op)
                    dsmc_pkg::OP_SET:
                        if (op_reg.axis)
                            ang_y_next = clamp_a;
                        else
                            ang_x_next = op_reg.a;
                    dsmc_pkg::OP_SET_BOTH:
                    begin
                        ang_x_next = op_reg.a;
                        ang_y_next = clamp_b;
                    end
                    dsmc_pkg::OP_ENQ:
                    begin
                        mem_we = 1'b1;
                        if (q_is_full)
                        begin
                            mem_wa = head_reg;
                            head_next = head_inc;
                            status_next = dsmc_pkg::ST_DROPPED;
                        end
                        else
                            count_next = count_reg + 1'b1;
                    end
                    dsmc_pkg::OP_CANCEL:
                    begin
                        count_next = '0;
                        active_next = 1'b0;
                    end
                    dsmc_pkg::OP_TICK:
                        status_next = dsmc_pkg::ST_OK;
                    default:
                        status_next = dsmc_pkg::ST_INVALID;
                endcase
            dsmc_pkg::S_POP:
            begin
                head_next = head_inc;
                count_next = count_reg - 1'b1;
                if (pop_go)
                begin
                    kind_next = rd_reg.kind;
                    div_start = 1'b1;
                    if (rd_reg.kind == dsmc_pkg::KIND_SYNC)
                    begin
                        start_x_next = ang_x_reg;
                        start_y_next = ang_y_reg;
                        tgt_x_next = rd_reg.a;
                        tgt_y_next = clamp_e_b;
                    end
                    else if (pop_single_y)
                    begin
                        start_y_next = ang_y_reg;
                        tgt_y_next = pop_target;
                    end
                    else
                    begin
                        start_x_next = ang_x_reg;
                        tgt_x_next = pop_target;
                    end
                end
            end
            dsmc_pkg::S_NWAIT:
                if (div_done)
                begin
                    total_next = (div_quo[15:0] == 16'd0) ? 16'd1 : div_quo[15:0];
                    idx_next = 16'd0;
                    active_next = 1'b1;
                end
            dsmc_pkg::S_ADV:
            begin
                idx_next = step_i;
                cur_ax_next = kind_reg == dsmc_pkg::KIND_Y;
                if (step_last)
                begin
                    active_next = 1'b0;
                    if (kind_reg != dsmc_pkg::KIND_Y)
                        ang_x_next = tgt_x_reg;
                    if (kind_reg != dsmc_pkg::KIND_X)
                        ang_y_next = tgt_y_reg;
                end
            end
            dsmc_pkg::S_MUL:
            begin
                neg_next = cur_t < cur_s;
                prod_next = 24'(cur_mag) * 24'(idx_reg);
            end
            dsmc_pkg::S_DSTART:
            begin
                div_start = 1'b1;
                div_dividend = prod_reg;
                div_divisor = total_reg;
            end
            dsmc_pkg::S_DWAIT:
                if (div_done)
                begin
                    if (cur_ax_reg)
                        ang_y_next = interp_v;
                    else
                        ang_x_next = interp_v;
                    if (kind_reg == dsmc_pkg::KIND_SYNC && !cur_ax_reg)
                        cur_ax_next = 1'b1;
                end
            dsmc_pkg::S_FIN:
                out_load = !out_valid_reg || !out_stall;
            default:
                out_load = 1'b0;
        endcase
        if (out_load)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dsmc_pkg::S_IDLE;
            ang_x_reg <= dsmc_pkg::X_RESET_DEG;
            ang_y_reg <= dsmc_pkg::Y_RESET_DEG;
            head_reg <= '0;
            count_reg <= '0;
            active_reg <= 1'b0;
            kind_reg <= dsmc_pkg::KIND_X;
            start_x_reg <= 8'd0;
            start_y_reg <= 8'd0;
            tgt_x_reg <= 8'd0;
            tgt_y_reg <= 8'd0;
            total_reg <= 16'd0;
            idx_reg <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ang_x_reg <= ang_x_next;
            ang_y_reg <= ang_y_next;
            head_reg <= head_next;
            count_reg <= count_next;
            active_reg <= active_next;
            kind_reg <= kind_next;
            start_x_reg <= start_x_next;
            start_y_reg <= start_y_next;
            tgt_x_reg <= tgt_x_next;
            tgt_y_reg <= tgt_y_next;
            total_reg <= total_next;
            idx_reg <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        status_reg <= status_next;
        cur_ax_reg <= cur_ax_next;
        neg_reg <= neg_next;
        prod_reg <= prod_next;
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_duty_x_reg <= dsmc_pkg::DUTY_LUT[ang_x_reg];
            out_duty_y_reg <= dsmc_pkg::DUTY_LUT[ang_y_reg];
            out_pos_x_reg <= ang_x_reg;
            out_pos_y_reg <= ang_y_reg;
            out_queued_reg <= count_wide[7:0];
            out_moving_reg <= active_reg;
        end
    end

    // move queue storage
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rd_reg <= mem[head_reg];
    end

    assign out_valid = out_valid_reg;
    assign status = out_status_reg;
    assign duty_x = out_duty_x_reg;
    assign duty_y = out_duty_y_reg;
    assign pos_x = out_pos_x_reg;
    assign pos_y = out_pos_y_reg;
    assign queued = out_queued_reg;
    assign moving = out_moving_reg;

endmodule
